// File: rtl/mspf_pkg.sv
// Shared types and constants for the motor speed PID/feedforward regulator.
// Used by every module under rtl/; depends on nothing else.
package mspf_pkg;

  localparam int unsigned DEF_CHANNELS       = 4;
  localparam int unsigned DEF_COUNTS_PER_REV = 1560;

  localparam int unsigned CH_W     = 2;
  localparam int unsigned CH_SLOTS = 1 << CH_W;

  // input register, three measurement stages, two integrator stages,
  // three drive stages (the last is the result register)
  localparam int unsigned STAGES = 9;

  localparam logic [3:0] SIGN_MASK_RST = 4'hF;
  localparam logic [9:0] OUT_LIMIT_RST = 10'd300;
  localparam logic [9:0] OUT_LIMIT_MAX = 10'd1000;

  typedef enum logic {
    REG_SIGN_MASK = 1'b0,
    REG_OUT_LIMIT = 1'b1
  } mspf_reg_e;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic               clr;
    logic signed [7:0]  tgt;
    logic signed [15:0] enc;
  } mspf_in_t;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic               clr;
    logic signed [15:0] cps;
    logic [22:0]        tprod;
    logic               tneg;
  } mspf_m1_t;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic               clr;
    logic signed [15:0] cps;
    logic [15:0]        rpm_mag;
    logic [17:0]        tq;
    logic               tneg;
  } mspf_m2_t;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic               clr;
    logic signed [15:0] cps;
    logic signed [11:0] rpm;
    logic signed [15:0] tc;
    logic signed [16:0] e;
  } mspf_m3_t;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic               clr;
    logic signed [15:0] cps;
    logic signed [11:0] rpm;
    logic signed [16:0] e;
    logic signed [27:0] inc;
    logic signed [22:0] a0;
  } mspf_m4_t;

  typedef struct packed {
    logic               ok;
    logic signed [15:0] cps;
    logic signed [11:0] rpm;
    logic signed [22:0] a0;
    logic signed [16:0] prev;
    logic signed [26:0] inew;
  } mspf_m5_t;

  typedef struct packed {
    logic               ok;
    logic signed [15:0] cps;
    logic signed [11:0] rpm;
    logic signed [22:0] f;
    logic               gz;
  } mspf_d6_t;

  typedef struct packed {
    logic               ok;
    logic signed [15:0] cps;
    logic signed [11:0] rpm;
    logic [16:0]        qu;
    logic [23:0]        u;
    logic               neg;
    logic               gz;
  } mspf_d7_t;

endpackage

// File: rtl/mspf_meas.sv
// Measurement and target conversion: counts/s with saturation, rpm rounded,
// target in counts/s, speed error. Three register stages. Uses mspf_pkg.
module mspf_meas #(
  parameter int unsigned COUNTS_PER_REV = mspf_pkg::DEF_COUNTS_PER_REV
) (
  input  logic              clk_i,
  input  logic [2:0]        ld_i,
  input  mspf_pkg::mspf_in_t in_i,
  input  logic [3:0]        sign_mask_i,
  output mspf_pkg::mspf_m3_t out_o
);
  import mspf_pkg::*;

  // exact floor(n/d) by multiply with ceil(2^(w+l)/d), l = clog2(d)
  localparam int unsigned RpmShift = 21 + $clog2(COUNTS_PER_REV);
  localparam logic [22:0] RpmRecip =
    23'(((64'd1 << RpmShift) + 64'(COUNTS_PER_REV) - 64'd1) / 64'(COUNTS_PER_REV));
  localparam logic [20:0] RpmHalf  = 21'(COUNTS_PER_REV / 2);
  localparam int unsigned TgtShift = 29;
  localparam logic [23:0] TgtRecip = 24'd8947849;  // ceil(2^29 / 60)

  mspf_m1_t m1_q, m1_d;
  mspf_m2_t m2_q, m2_d;
  mspf_m3_t m3_q, m3_d;

  logic signed [16:0] a;
  logic signed [21:0] p;
  logic [7:0]         tmag;
  logic [15:0]        mag;
  logic [20:0]        nr;
  logic [43:0]        rprod;
  logic [46:0]        tprod_m;

  // stage 1: sign, scale to counts/s, saturate; target magnitude times CPR
  always_comb begin
    a = 17'(in_i.enc);
    if (sign_mask_i[in_i.ch]) begin
      a = -a;
    end
    p = 22'(a) * 22'sd50;
    m1_d.ch  = in_i.ch;
    m1_d.clr = in_i.clr;
    if (p > 22'sd32767) begin
      m1_d.cps = 16'sh7FFF;
    end else if (p < -22'sd32768) begin
      m1_d.cps = 16'sh8000;
    end else begin
      m1_d.cps = 16'(p);
    end
    tmag        = in_i.tgt[7] ? 8'(-in_i.tgt) : 8'(in_i.tgt);
    m1_d.tneg   = in_i.tgt[7];
    m1_d.tprod  = 23'(tmag) * 23'(COUNTS_PER_REV);
  end

  // stage 2: both constant divisions
  always_comb begin
    mag     = m1_q.cps[15] ? 16'(-m1_q.cps) : 16'(m1_q.cps);
    nr      = (21'(mag) << 6) - (21'(mag) << 2) + RpmHalf;
    rprod   = 44'(nr) * 44'(RpmRecip);
    tprod_m = 47'(m1_q.tprod) * 47'(TgtRecip);
    m2_d.ch      = m1_q.ch;
    m2_d.clr     = m1_q.clr;
    m2_d.cps     = m1_q.cps;
    m2_d.rpm_mag = 16'(rprod >> RpmShift);
    m2_d.tq      = 18'(tprod_m >> TgtShift);
    m2_d.tneg    = m1_q.tneg;
  end

  // stage 3: signs and saturation, error
  always_comb begin
    m3_d.ch  = m2_q.ch;
    m3_d.clr = m2_q.clr;
    m3_d.cps = m2_q.cps;
    if (m2_q.cps[15]) begin
      m3_d.rpm = (m2_q.rpm_mag > 16'd2048) ? 12'sh800 : -12'(m2_q.rpm_mag);
    end else begin
      m3_d.rpm = (m2_q.rpm_mag > 16'd2047) ? 12'sh7FF : 12'(m2_q.rpm_mag);
    end
    if (m2_q.tneg) begin
      m3_d.tc = (m2_q.tq > 18'd32768) ? 16'sh8000 : -16'(m2_q.tq);
    end else begin
      m3_d.tc = (m2_q.tq > 18'd32767) ? 16'sh7FFF : 16'(m2_q.tq);
    end
    m3_d.e = 17'(m3_d.tc) - 17'(m2_q.cps);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      m1_q <= m1_d;
    end
    if (ld_i[1]) begin
      m2_q <= m2_d;
    end
    if (ld_i[2]) begin
      m3_q <= m3_d;
    end
  end

  assign out_o = m3_q;

endmodule

// File: rtl/mspf_integ.sv
// Integral increment and per-channel state (error integral, last error).
// Read, update and write of the state happen in one stage. Uses mspf_pkg.
module mspf_integ #(
  parameter int unsigned CHANNELS = mspf_pkg::DEF_CHANNELS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         ld_i,
  input  mspf_pkg::mspf_m3_t in_i,
  output mspf_pkg::mspf_m5_t out_o
);
  import mspf_pkg::*;

  localparam int unsigned Slots     = (CHANNELS < CH_SLOTS) ? CHANNELS : CH_SLOTS;
  localparam logic [22:0] IncRecip  = 23'd5368710;  // ceil(2^28 / 50)
  localparam int unsigned IncShift  = 28;
  localparam logic signed [28:0] IntegLim = 29'sd65536000;  // 1000.0 in Q16

  mspf_m4_t m4_q, m4_d;
  mspf_m5_t m5_q, m5_d;

  logic signed [26:0] integ_q [Slots];
  logic signed [16:0] prev_q  [Slots];

  logic [15:0]        e_m;
  logic [21:0]        x;
  logic [44:0]        xprod;
  logic [26:0]        inc_m;
  logic signed [22:0] tc_w;
  logic signed [22:0] e_w;
  logic signed [26:0] iold;
  logic signed [16:0] pold;
  logic signed [28:0] isum;
  logic               ok;

  // increment = e*2^16/50 rounded half away: 1310*|e| + (36*|e| + 25)/50
  always_comb begin
    e_m   = in_i.e[16] ? 16'(-in_i.e) : 16'(in_i.e);
    x     = (22'(e_m) << 5) + (22'(e_m) << 2) + 22'd25;
    xprod = 45'(x) * 45'(IncRecip);
    inc_m = 27'(e_m) * 27'd1310 + 27'(xprod >> IncShift);
    tc_w  = 23'(in_i.tc);
    e_w   = 23'(in_i.e);
    m4_d.ch  = in_i.ch;
    m4_d.clr = in_i.clr;
    m4_d.cps = in_i.cps;
    m4_d.rpm = in_i.rpm;
    m4_d.e   = in_i.e;
    m4_d.inc = in_i.e[16] ? -28'(inc_m) : 28'(inc_m);
    // feedforward and proportional/derivative terms that need no state
    m4_d.a0  = tc_w * 23'sd40 + e_w * 23'sd13;
    if (in_i.tc > 16'sd0) begin
      m4_d.a0 = m4_d.a0 + 23'sd2000;
    end else if (in_i.tc < 16'sd0) begin
      m4_d.a0 = m4_d.a0 - 23'sd2000;
    end
  end

  always_comb begin
    iold = '0;
    pold = '0;
    for (int c = 0; c < Slots; c++) begin
      if (m4_q.ch == CH_W'(c)) begin
        iold = integ_q[c];
        pold = prev_q[c];
      end
    end
    if (m4_q.clr) begin
      iold = '0;
      pold = '0;
    end
    ok   = int'(m4_q.ch) < CHANNELS;
    isum = 29'(iold) + 29'(m4_q.inc);
    m5_d.ok   = ok;
    m5_d.cps  = m4_q.cps;
    m5_d.rpm  = m4_q.rpm;
    m5_d.a0   = m4_q.a0;
    m5_d.prev = pold;
    if (isum > IntegLim) begin
      m5_d.inew = 27'(IntegLim);
    end else if (isum < -IntegLim) begin
      m5_d.inew = 27'(-IntegLim);
    end else begin
      m5_d.inew = 27'(isum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < Slots; c++) begin
        integ_q[c] <= '0;
        prev_q[c]  <= '0;
      end
    end else if (ld_i[1]) begin
      for (int c = 0; c < Slots; c++) begin
        if (ok && m4_q.ch == CH_W'(c)) begin
          integ_q[c] <= m5_d.inew;
          prev_q[c]  <= m4_q.e;
        end else if (m4_q.clr) begin
          integ_q[c] <= '0;
          prev_q[c]  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      m4_q <= m4_d;
    end
    if (ld_i[1]) begin
      m5_q <= m5_d;
    end
  end

  assign out_o = m5_q;

endmodule

// File: rtl/mspf_drive.sv
// Drive command: exact sum of the PID/feedforward terms, truncating division
// by 100*2^16, clamp to the output limit; holds the result register. Uses mspf_pkg.
module mspf_drive (
  input  logic                clk_i,
  input  logic [2:0]          ld_i,
  input  mspf_pkg::mspf_m5_t  in_i,
  input  logic [9:0]          out_limit_i,
  output logic signed [10:0]  drive_o,
  output logic signed [11:0]  rpm_o,
  output logic signed [15:0]  cps_o
);
  import mspf_pkg::*;

  localparam logic [23:0] Offset   = 24'd4194400;   // 100 * 41944, keeps F+Offset >= 0
  localparam logic [17:0] OffsetQ  = 18'd41944;
  localparam logic [24:0] DivRecip = 25'd21474837;  // ceil(2^31 / 100)
  localparam int unsigned DivShift = 31;

  mspf_d6_t d6_q, d6_d;
  mspf_d7_t d7_q, d7_d;

  logic signed [10:0] drive_q, drive_d;
  logic signed [11:0] rpm_q;
  logic signed [15:0] cps_q;

  logic signed [10:0] ih;
  logic [19:0]        fl;
  logic [48:0]        uprod;
  logic [23:0]        qu100;
  logic               exact;
  logic signed [17:0] q;
  logic signed [17:0] lim;

  // num = 2^16*(a0 - 5*prev + 10*Ih) + 10*Il; fold the carry of 10*Il into F
  always_comb begin
    ih = 11'(in_i.inew >>> 16);
    fl = (20'(in_i.inew[15:0]) << 3) + (20'(in_i.inew[15:0]) << 1);
    d6_d.ok  = in_i.ok;
    d6_d.cps = in_i.cps;
    d6_d.rpm = in_i.rpm;
    d6_d.f   = in_i.a0 - 23'(in_i.prev) * 23'sd5 + 23'(ih) * 23'sd10
             + $signed(23'(fl[19:16]));
    d6_d.gz  = (fl[15:0] == 16'd0);
  end

  always_comb begin
    d7_d.ok  = d6_q.ok;
    d7_d.cps = d6_q.cps;
    d7_d.rpm = d6_q.rpm;
    d7_d.u   = 24'(d6_q.f) + Offset;
    uprod    = 49'(d7_d.u) * 49'(DivRecip);
    d7_d.qu  = 17'(uprod >> DivShift);
    d7_d.neg = d6_q.f[22];
    d7_d.gz  = d6_q.gz;
  end

  // floor to truncation: negative sums step up unless exactly divisible
  always_comb begin
    qu100 = (24'(d7_q.qu) << 6) + (24'(d7_q.qu) << 5) + (24'(d7_q.qu) << 2);
    exact = d7_q.gz && (qu100 == d7_q.u);
    q     = $signed({1'b0, d7_q.qu}) - $signed(OffsetQ);
    if (d7_q.neg && !exact) begin
      q = q + 18'sd1;
    end
    lim = (out_limit_i > OUT_LIMIT_MAX) ? $signed(18'(OUT_LIMIT_MAX))
                                        : $signed(18'(out_limit_i));
    if (q > lim) begin
      q = lim;
    end else if (q < -lim) begin
      q = -lim;
    end
    drive_d = d7_q.ok ? 11'(q) : 11'sd0;
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      d6_q <= d6_d;
    end
    if (ld_i[1]) begin
      d7_q <= d7_d;
    end
    if (ld_i[2]) begin
      drive_q <= drive_d;
      rpm_q   <= d7_q.rpm;
      cps_q   <= d7_q.cps;
    end
  end

  assign drive_o = drive_q;
  assign rpm_o   = rpm_q;
  assign cps_o   = cps_q;

endmodule

// File: rtl/motor_speed_pid_feedforward.sv
// Top level of the motor speed PID/feedforward regulator: input register,
// pipeline flow control and APB registers. Uses mspf_pkg, mspf_meas,
// mspf_integ and mspf_drive.
//
// Per transfer the block measures the speed of the named channel (counts/s
// saturated to 16 bits, rpm rounded half away from zero), converts the rpm
// target to counts/s and returns a PID drive with feedforward, truncated and
// clamped to +-output_limit (capped at 1000). One transfer is accepted every
// clock while in_ready_o is high; each result passes through the nine register
// stages: input register, three measurement stages, two integrator stages
// (state read, update and write in the second) and three drive stages ending
// in the result register. Stalled results only hold the stages that are full;
// empty stages keep taking transfers. Channel state clears on reset and on
// clear_state; a channel at or above CHANNELS gets drive 0 and keeps no state.
// Registers: 0x0 channel_sign_mask (reset 0xF), 0x4 output_limit (reset 300).
module motor_speed_pid_feedforward #(
  parameter int unsigned CHANNELS       = mspf_pkg::DEF_CHANNELS,
  parameter int unsigned COUNTS_PER_REV = mspf_pkg::DEF_COUNTS_PER_REV
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         channel_i,
  input  logic signed [7:0]  target_rpm_i,
  input  logic signed [15:0] encoder_count_i,
  input  logic               clear_state_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [10:0] drive_permille_o,
  output logic signed [11:0] measured_rpm_o,
  output logic signed [15:0] measured_cps_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mspf_pkg::*;

  logic [STAGES-1:0] v_q, v_d;
  logic [STAGES-1:0] go;
  logic [STAGES-1:0] ld;
  logic [STAGES:0]   free;

  logic [3:0] sign_mask_q, sign_mask_d;
  logic [9:0] out_limit_q, out_limit_d;
  mspf_reg_e  reg_sel;

  mspf_in_t in_q, in_d;
  mspf_m3_t m3;
  mspf_m5_t m5;

  // a stage is free when empty or when its item moves on this cycle
  always_comb begin
    free[STAGES] = out_ready_i;
    for (int k = STAGES - 1; k >= 0; k--) begin
      go[k]   = v_q[k] & free[k+1];
      free[k] = ~v_q[k] | free[k+1];
    end
    ld[0] = in_valid_i & free[0];
    for (int k = 1; k < STAGES; k++) begin
      ld[k] = go[k-1];
    end
    v_d = ld | (v_q & ~go);
  end

  assign in_ready_o  = free[0];
  assign out_valid_o = v_q[STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_comb begin
    in_d.ch  = channel_i;
    in_d.clr = clear_state_i;
    in_d.tgt = target_rpm_i;
    in_d.enc = encoder_count_i;
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      in_q <= in_d;
    end
  end

  // APB registers
  assign reg_sel = mspf_reg_e'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    sign_mask_d = sign_mask_q;
    out_limit_d = out_limit_q;
    if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_SIGN_MASK: sign_mask_d = pwdata[3:0];
        REG_OUT_LIMIT: out_limit_d = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SIGN_MASK: prdata = {28'd0, sign_mask_q};
      REG_OUT_LIMIT: prdata = {22'd0, out_limit_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_mask_q <= SIGN_MASK_RST;
      out_limit_q <= OUT_LIMIT_RST;
    end else begin
      sign_mask_q <= sign_mask_d;
      out_limit_q <= out_limit_d;
    end
  end

  mspf_meas #(
    .COUNTS_PER_REV(COUNTS_PER_REV)
  ) u_meas (
    .clk_i      (clk_i),
    .ld_i       (ld[3:1]),
    .in_i       (in_q),
    .sign_mask_i(sign_mask_q),
    .out_o      (m3)
  );

  mspf_integ #(
    .CHANNELS(CHANNELS)
  ) u_integ (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ld_i  (ld[5:4]),
    .in_i  (m3),
    .out_o (m5)
  );

  mspf_drive u_drive (
    .clk_i      (clk_i),
    .ld_i       (ld[8:6]),
    .in_i       (m5),
    .out_limit_i(out_limit_q),
    .drive_o    (drive_permille_o),
    .rpm_o      (measured_rpm_o),
    .cps_o      (measured_cps_o)
  );

endmodule
